/* rtl/core/gfhp_pkg.sv */
// ----------------------------------------------------------------------------
// gfhp_pkg
// shared types and constants of the frame header parser
// ----------------------------------------------------------------------------
package gfhp_pkg;

  // varint length field limit in bytes
  localparam int unsigned LEN_BYTES_MAX = 5;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned PLEN_W    = 32;
  localparam int unsigned HLEN_W    = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned SEEN_W    = 3;
  localparam int unsigned OUT_TDATA_W = 40;

  // byte positions inside the header
  localparam logic [POS_W-1:0] POS_FLAG     = 3'd0;
  localparam logic [POS_W-1:0] POS_LEN_LAST = 3'd4;
  localparam logic [POS_W-1:0] POS_TAG      = 3'd5;
  localparam logic [POS_W-1:0] POS_VARINT   = 3'd6;

  // byte values
  localparam logic [DATA_W-1:0] COMP_IDENTITY = 8'h00;
  localparam logic [DATA_W-1:0] TAG_FIELD1    = 8'h0A;
  localparam logic [DATA_W-1:0] VARINT_MASK   = 8'h7F;
  localparam logic [DATA_W-1:0] VARINT_CONT   = 8'h80;

  localparam logic [HLEN_W-1:0]  FIXED_BYTES   = 4'd6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 32'd1048576;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_FLAG   = 3'd1,
    ST_BAD_TAG    = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_OVER_LIMIT = 3'd4,
    ST_MISMATCH   = 3'd5,
    ST_TRUNCATED  = 3'd6
  } status_e;

endpackage

/* rtl/core/grpc_frame_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// grpc_frame_header_parser_unit
// streaming parser of a length-prefixed frame header with a varint length
// ----------------------------------------------------------------------------
//  channel  dir  beat contents (lsb first)                   accepted when
//  s_axis   in   tdata: data_byte; tuser: frame_start;       tvalid & tready
//                tlast: buffer_end
//  m_axis   out  tdata: status, payload_length,              tvalid & tready
//                header_length
//  cfg      in   data: payload_limit                         valid & ready
//
//  one byte per cycle while the result register is not stalled: each beat
//  passes an input register, then update logic (32-bit limit compare and
//  33-bit length add) writes the parser state and, when the frame is
//  decided, the result register.
//  reset clears the parser to idle (waiting for frame start) and restores
//  the payload limit. a stalled result register holds the input register,
//  which in turn drops s_axis_tready_o; cfg is always ready.
// ----------------------------------------------------------------------------
module grpc_frame_header_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // data_byte[7:0]
  input  logic [gfhp_pkg::DATA_W-1:0]       s_axis_tdata_i,
  // frame_start[0]
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // status[2:0], payload_length[34:3], header_length[38:35], zero[39]
  output logic [gfhp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic [gfhp_pkg::LIMIT_W-1:0]      cfg_data_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o
);
  import gfhp_pkg::*;

  // configuration
  logic [LIMIT_W-1:0] limit_q;

  // input register
  logic              in_valid_q;
  logic [DATA_W-1:0] in_byte_q;
  logic              in_start_q;
  logic              in_last_q;

  // parser state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PLEN_W-1:0]  dfl_q, dfl_d;
  logic [PLEN_W-1:0]  acc_q, acc_d;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic               decided_q, decided_d;

  // result register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [PLEN_W-1:0]  out_plen_q;
  logic [HLEN_W-1:0]  out_hlen_q;

  // update path
  logic               advance;
  logic               active;
  logic [POS_W-1:0]   pos_e;
  logic [PLEN_W-1:0]  dfl_e;
  logic [PLEN_W-1:0]  acc_e;
  logic [SEEN_W-1:0]  seen_e;
  logic [PLEN_W-1:0]  acc_shift;
  logic [PLEN_W-1:0]  acc_new;
  logic [SEEN_W-1:0]  seen_new;
  logic [PLEN_W:0]    expected;
  logic               emit;
  status_e            res_status;
  logic [PLEN_W-1:0]  res_plen;
  logic [HLEN_W-1:0]  res_hlen;

  // the input stage moves on when the result register is free or drains
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign active = in_valid_q && advance && (in_start_q || !decided_q);

  // frame start restarts the parser on this very byte
  always_comb begin
    pos_e  = in_start_q ? POS_FLAG : pos_q;
    dfl_e  = in_start_q ? '0 : dfl_q;
    acc_e  = in_start_q ? '0 : acc_q;
    seen_e = in_start_q ? '0 : seen_q;
  end

  // seven payload bits per varint byte, bits above 31 dropped
  always_comb begin
    case (seen_e)
      3'd0:    acc_shift = {25'd0, in_byte_q[6:0]};
      3'd1:    acc_shift = {18'd0, in_byte_q[6:0], 7'd0};
      3'd2:    acc_shift = {11'd0, in_byte_q[6:0], 14'd0};
      3'd3:    acc_shift = {4'd0, in_byte_q[6:0], 21'd0};
      3'd4:    acc_shift = {in_byte_q[3:0], 28'd0};
      default: acc_shift = '0;
    endcase
  end

  assign acc_new  = acc_e | (acc_shift & {24'd0, VARINT_MASK} << 0 | acc_shift);
  assign seen_new = seen_e + SEEN_W'(1);
  assign expected = (PLEN_W+1)'(seen_new) + {1'b0, acc_new} + (PLEN_W+1)'(1);

  always_comb begin
    pos_d      = pos_q;
    dfl_d      = dfl_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    decided_d  = decided_q;
    emit       = 1'b0;
    res_status = ST_OK;
    res_plen   = '0;
    res_hlen   = '0;
    if (active) begin
      decided_d = 1'b0;
      pos_d     = pos_e;
      dfl_d     = dfl_e;
      acc_d     = acc_e;
      seen_d    = seen_e;
      if (pos_e == POS_FLAG) begin
        if (in_byte_q != COMP_IDENTITY) begin
          emit       = 1'b1;
          res_status = ST_BAD_FLAG;
        end else begin
          pos_d = pos_e + POS_W'(1);
        end
      end else if (pos_e <= POS_LEN_LAST) begin
        // big-endian frame length
        dfl_d = {dfl_e[PLEN_W-DATA_W-1:0], in_byte_q};
        pos_d = pos_e + POS_W'(1);
      end else if (pos_e == POS_TAG) begin
        if (in_byte_q != TAG_FIELD1) begin
          emit       = 1'b1;
          res_status = ST_BAD_TAG;
        end else begin
          pos_d = POS_VARINT;
        end
      end else begin
        acc_d  = acc_new;
        seen_d = seen_new;
        if ((in_byte_q & VARINT_CONT) == '0) begin
          emit = 1'b1;
          if (acc_new > limit_q) begin
            res_status = ST_OVER_LIMIT;
          end else if ({1'b0, dfl_e} != expected) begin
            res_status = ST_MISMATCH;
          end else begin
            res_status = ST_OK;
            res_plen   = acc_new;
            res_hlen   = FIXED_BYTES + HLEN_W'(seen_new);
          end
        end else if (seen_new >= SEEN_W'(LEN_BYTES_MAX)) begin
          emit       = 1'b1;
          res_status = ST_TOO_LONG;
        end
      end
      // buffer ran out before the frame was decided
      if (!emit && in_last_q) begin
        emit       = 1'b1;
        res_status = ST_TRUNCATED;
      end
      if (emit) begin
        decided_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_FLAG;
      dfl_q     <= '0;
      acc_q     <= '0;
      seen_q    <= '0;
      decided_q <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      dfl_q     <= dfl_d;
      acc_q     <= acc_d;
      seen_q    <= seen_d;
      decided_q <= decided_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= res_status;
      out_plen_q   <= res_plen;
      out_hlen_q   <= res_hlen;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_hlen_q, out_plen_q, out_status_q};

`ifndef SYNTHESIS
  // a good header always carries one to five varint bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_OK) |->
      (out_hlen_q >= 4'd7 && out_hlen_q <= 4'd11))
    else $error("header length out of range on ok result");

  // failed frames report no lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_plen_q == '0 && out_hlen_q == '0))
    else $error("lengths not cleared on failed frame");

  // a decision always leaves the parser idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> decided_q)
    else $error("parser not idle after result");

  // the byte position never runs past the varint field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_VARINT)
    else $error("byte position out of range");
`endif

endmodule
